@@ rtl/mtq_pkg.sv @@
// Shared types, sizes and codes for the max-tracking FIFO queue.
`default_nettype none
package mtq_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int TAG_BITS   = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    // max-stack store: head stack in the lower half, tail stack in the upper half
    localparam int MAX_AW     = ADDR_W + 1;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    // unused code, behaves as a query
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic HEAD_REGION = 1'b0;
    localparam logic TAIL_REGION = 1'b1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] weight;
        logic [VALUE_BITS-1:0] price;
        logic [TAG_BITS-1:0]   tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [ADDR_W-1:0] slot;
        t_entry            entry;
    } t_max_rec;

    localparam int MAX_REC_W = $bits(t_max_rec);

    typedef struct packed {
        t_entry           front;
        t_entry           best;
        logic [CNT_W-1:0] occupancy;
        logic [1:0]       error_code;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK,
        ST_RESULT
    } t_state;

    // circular slot arithmetic: base < DEPTH, off <= DEPTH
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/max_tracking_fifo_queue_core.sv @@
// Top level of the max-tracking FIFO queue (two-stack max queue).
// FIFO of up to 64 entries (weight, price, tag) that reports, after every push, pop or query,
// the oldest entry, the highest-price entry and the fill level. One result per accepted
// transfer. Push and query go from idle straight to the result state; a pop first passes
// through a pop state for a read of the entry store and, when the popped entry was the head
// maximum, of the head max stack, which return data in the next cycle. A pop on an empty
// queue skips that state. A pop that empties the head stack then moves the whole tail stack
// across, one entry store read per cycle; each entry makes that move at most once. A result
// held by a stalled output channel keeps the next item waiting until it has gone. Ties on
// price favour the head stack. Pop on empty (error 1) and push on full (error 2) leave the
// queue untouched. The stores need no clearing after reset.
`default_nettype none
module max_tracking_fifo_queue_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_func,
    input  wire logic [mtq_pkg::VALUE_BITS-1:0]    i_item_weight,
    input  wire logic [mtq_pkg::VALUE_BITS-1:0]    i_item_price,
    input  wire logic [mtq_pkg::TAG_BITS-1:0]      i_item_tag,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [mtq_pkg::VALUE_BITS-1:0]         o_front_weight,
    output logic [mtq_pkg::VALUE_BITS-1:0]         o_front_price,
    output logic [mtq_pkg::TAG_BITS-1:0]           o_front_tag,
    output logic [mtq_pkg::VALUE_BITS-1:0]         o_best_weight,
    output logic [mtq_pkg::VALUE_BITS-1:0]         o_best_price,
    output logic [mtq_pkg::TAG_BITS-1:0]           o_best_tag,
    output logic [mtq_pkg::CNT_W-1:0]              o_occupancy,
    output logic [1:0]                             o_error_code
);

    mtq_pkg::t_entry                  item;
    logic                             ent_wr_en;
    logic [mtq_pkg::ADDR_W-1:0]       ent_wr_addr;
    mtq_pkg::t_entry                  ent_wr_data;
    logic                             ent_rd_en;
    logic [mtq_pkg::ADDR_W-1:0]       ent_rd_addr;
    mtq_pkg::t_entry                  ent_rd_data;
    logic                             max_wr_en;
    logic [mtq_pkg::MAX_AW-1:0]       max_wr_addr;
    mtq_pkg::t_max_rec                max_wr_data;
    logic                             max_rd_en;
    logic [mtq_pkg::MAX_AW-1:0]       max_rd_addr;
    mtq_pkg::t_max_rec                max_rd_data;
    logic                             res_valid;
    logic                             res_ready;
    mtq_pkg::t_result                 res;
    mtq_pkg::t_result                 out_res;

    assign item = '{weight: i_item_weight, price: i_item_price, tag: i_item_tag};

    mtq_ram #(
        .WIDTH (mtq_pkg::ENTRY_W),
        .AW    (mtq_pkg::ADDR_W)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data)
    );

    mtq_ram #(
        .WIDTH (mtq_pkg::MAX_REC_W),
        .AW    (mtq_pkg::MAX_AW)
    ) u_max_ram (
        .i_clk     (i_clk),
        .i_wr_en   (max_wr_en),
        .i_wr_addr (max_wr_addr),
        .i_wr_data (max_wr_data),
        .i_rd_en   (max_rd_en),
        .i_rd_addr (max_rd_addr),
        .o_rd_data (max_rd_data)
    );

    mtq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_item        (item),
        .o_ent_wr_en   (ent_wr_en),
        .o_ent_wr_addr (ent_wr_addr),
        .o_ent_wr_data (ent_wr_data),
        .o_ent_rd_en   (ent_rd_en),
        .o_ent_rd_addr (ent_rd_addr),
        .i_ent_rd_data (ent_rd_data),
        .o_max_wr_en   (max_wr_en),
        .o_max_wr_addr (max_wr_addr),
        .o_max_wr_data (max_wr_data),
        .o_max_rd_en   (max_rd_en),
        .o_max_rd_addr (max_rd_addr),
        .i_max_rd_data (max_rd_data),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    mtq_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_front_weight = out_res.front.weight;
    assign o_front_price  = out_res.front.price;
    assign o_front_tag    = out_res.front.tag;
    assign o_best_weight  = out_res.best.weight;
    assign o_best_price   = out_res.best.price;
    assign o_best_tag     = out_res.best.tag;
    assign o_occupancy    = out_res.occupancy;
    assign o_error_code   = out_res.error_code;

endmodule
`default_nettype wire

@@ rtl/mtq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module mtq_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:(1 << AW)-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/mtq_ctrl.sv @@
// Queue sequencer: stack counters, cached tops, memory accesses and tail-to-head move.
`default_nettype none
module mtq_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_func,
    input  wire mtq_pkg::t_entry              i_item,
    output logic                              o_ent_wr_en,
    output logic [mtq_pkg::ADDR_W-1:0]        o_ent_wr_addr,
    output mtq_pkg::t_entry                   o_ent_wr_data,
    output logic                              o_ent_rd_en,
    output logic [mtq_pkg::ADDR_W-1:0]        o_ent_rd_addr,
    input  wire mtq_pkg::t_entry              i_ent_rd_data,
    output logic                              o_max_wr_en,
    output logic [mtq_pkg::MAX_AW-1:0]        o_max_wr_addr,
    output mtq_pkg::t_max_rec                 o_max_wr_data,
    output logic                              o_max_rd_en,
    output logic [mtq_pkg::MAX_AW-1:0]        o_max_rd_addr,
    input  wire mtq_pkg::t_max_rec            i_max_rd_data,
    output logic                              o_res_valid,
    output mtq_pkg::t_result                  o_res,
    input  wire logic                         i_res_ready
);

    mtq_pkg::t_state                  r_state,    n_state;
    logic [mtq_pkg::ADDR_W-1:0]       r_oldest,   n_oldest;
    logic [mtq_pkg::CNT_W-1:0]        r_head_cnt, n_head_cnt;
    logic [mtq_pkg::CNT_W-1:0]        r_tail_cnt, n_tail_cnt;
    logic [mtq_pkg::CNT_W-1:0]        r_hmc,      n_hmc;
    logic [mtq_pkg::CNT_W-1:0]        r_tmc,      n_tmc;
    mtq_pkg::t_entry                  r_front,    n_front;
    mtq_pkg::t_max_rec                r_hm,       n_hm;
    mtq_pkg::t_max_rec                r_tm,       n_tm;
    logic [1:0]                       r_err,      n_err;
    logic [mtq_pkg::ADDR_W-1:0]       r_walk_k,   n_walk_k;
    logic                             r_reload,   n_reload;

    logic [mtq_pkg::CNT_W-1:0]        w_occ;
    logic [mtq_pkg::CNT_W-1:0]        w_hmc_m2;
    logic [mtq_pkg::ADDR_W-1:0]       w_push_slot;
    logic [mtq_pkg::ADDR_W-1:0]       w_next_oldest;
    logic [mtq_pkg::ADDR_W-1:0]       w_walk_slot;
    mtq_pkg::t_max_rec                w_push_rec;
    mtq_pkg::t_max_rec                w_walk_rec;

    assign w_occ         = r_head_cnt + r_tail_cnt;
    assign w_hmc_m2      = r_hmc - mtq_pkg::CNT_W'(2);
    assign w_push_slot   = mtq_pkg::slot_add(r_oldest, w_occ);
    assign w_next_oldest = mtq_pkg::slot_add(r_oldest, mtq_pkg::CNT_W'(1));
    assign w_walk_slot   = mtq_pkg::slot_add(r_oldest, mtq_pkg::CNT_W'(r_walk_k));
    assign w_push_rec    = '{slot: w_push_slot, entry: i_item};
    assign w_walk_rec    = '{slot: w_walk_slot, entry: i_ent_rd_data};

    assign o_in_stall = !i_rst_n || (r_state != mtq_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mtq_pkg::ST_IDLE;
            r_oldest   <= '0;
            r_head_cnt <= '0;
            r_tail_cnt <= '0;
            r_hmc      <= '0;
            r_tmc      <= '0;
        end else begin
            r_state    <= n_state;
            r_oldest   <= n_oldest;
            r_head_cnt <= n_head_cnt;
            r_tail_cnt <= n_tail_cnt;
            r_hmc      <= n_hmc;
            r_tmc      <= n_tmc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_hm     <= n_hm;
        r_tm     <= n_tm;
        r_err    <= n_err;
        r_walk_k <= n_walk_k;
        r_reload <= n_reload;
    end

    always_comb begin
        n_state    = r_state;
        n_oldest   = r_oldest;
        n_head_cnt = r_head_cnt;
        n_tail_cnt = r_tail_cnt;
        n_hmc      = r_hmc;
        n_tmc      = r_tmc;
        n_front    = r_front;
        n_hm       = r_hm;
        n_tm       = r_tm;
        n_err      = r_err;
        n_walk_k   = r_walk_k;
        n_reload   = r_reload;

        o_ent_wr_en   = 1'b0;
        o_ent_wr_addr = w_push_slot;
        o_ent_wr_data = i_item;
        o_ent_rd_en   = 1'b0;
        o_ent_rd_addr = w_next_oldest;
        o_max_wr_en   = 1'b0;
        o_max_wr_addr = {mtq_pkg::TAIL_REGION, r_tmc[mtq_pkg::ADDR_W-1:0]};
        o_max_wr_data = w_push_rec;
        o_max_rd_en   = 1'b0;
        o_max_rd_addr = {mtq_pkg::HEAD_REGION, w_hmc_m2[mtq_pkg::ADDR_W-1:0]};
        o_res_valid   = 1'b0;

        unique case (r_state)
            mtq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_err   = mtq_pkg::ERR_OK;
                    n_state = mtq_pkg::ST_RESULT;
                    case (i_func)
                        mtq_pkg::FUNC_PUSH: begin
                            if (w_occ == mtq_pkg::CNT_W'(mtq_pkg::DEPTH)) begin
                                n_err = mtq_pkg::ERR_FULL;
                            end else if (r_head_cnt == '0) begin
                                // empty queue: the new entry goes straight to the head
                                o_ent_wr_en   = 1'b1;
                                o_max_wr_en   = 1'b1;
                                o_max_wr_addr = {mtq_pkg::HEAD_REGION,
                                                 {mtq_pkg::ADDR_W{1'b0}}};
                                n_hm          = w_push_rec;
                                n_hmc         = mtq_pkg::CNT_W'(1);
                                n_front       = i_item;
                                n_head_cnt    = mtq_pkg::CNT_W'(1);
                            end else begin
                                o_ent_wr_en = 1'b1;
                                if (r_tmc == '0 || i_item.price >= r_tm.entry.price) begin
                                    o_max_wr_en = 1'b1;
                                    n_tm        = w_push_rec;
                                    n_tmc       = r_tmc + mtq_pkg::CNT_W'(1);
                                end
                                n_tail_cnt = r_tail_cnt + mtq_pkg::CNT_W'(1);
                            end
                        end
                        mtq_pkg::FUNC_POP: begin
                            if (w_occ == '0) begin
                                n_err = mtq_pkg::ERR_EMPTY;
                            end else begin
                                n_oldest    = w_next_oldest;
                                n_head_cnt  = r_head_cnt - mtq_pkg::CNT_W'(1);
                                o_ent_rd_en = 1'b1;
                                n_reload    = (r_hm.slot == r_oldest);
                                if (r_hm.slot == r_oldest) begin
                                    n_hmc       = r_hmc - mtq_pkg::CNT_W'(1);
                                    o_max_rd_en = (r_hmc > mtq_pkg::CNT_W'(1));
                                end
                                n_state = mtq_pkg::ST_POP;
                            end
                        end
                        mtq_pkg::FUNC_QUERY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mtq_pkg::ST_POP: begin
                if (r_head_cnt == '0) begin
                    if (r_tail_cnt != '0) begin
                        // head ran dry: move the tail across, newest first
                        o_ent_rd_en   = 1'b1;
                        o_ent_rd_addr = mtq_pkg::slot_add(r_oldest,
                                                          r_tail_cnt - mtq_pkg::CNT_W'(1));
                        n_walk_k      = mtq_pkg::ADDR_W'(r_tail_cnt - mtq_pkg::CNT_W'(1));
                        n_state       = mtq_pkg::ST_WALK;
                    end else begin
                        n_state = mtq_pkg::ST_RESULT;
                    end
                end else begin
                    n_front = i_ent_rd_data;
                    if (r_reload) begin
                        n_hm = i_max_rd_data;
                    end
                    n_state = mtq_pkg::ST_RESULT;
                end
            end
            mtq_pkg::ST_WALK: begin
                if (r_hmc == '0 || i_ent_rd_data.price >= r_hm.entry.price) begin
                    o_max_wr_en   = 1'b1;
                    o_max_wr_addr = {mtq_pkg::HEAD_REGION, r_hmc[mtq_pkg::ADDR_W-1:0]};
                    o_max_wr_data = w_walk_rec;
                    n_hm          = w_walk_rec;
                    n_hmc         = r_hmc + mtq_pkg::CNT_W'(1);
                end
                if (r_walk_k == '0) begin
                    // last one read is the oldest entry
                    n_front    = i_ent_rd_data;
                    n_head_cnt = r_tail_cnt;
                    n_tail_cnt = '0;
                    n_tmc      = '0;
                    n_state    = mtq_pkg::ST_RESULT;
                end else begin
                    o_ent_rd_en   = 1'b1;
                    o_ent_rd_addr = mtq_pkg::slot_add(r_oldest,
                                        mtq_pkg::CNT_W'(r_walk_k) - mtq_pkg::CNT_W'(1));
                    n_walk_k      = r_walk_k - mtq_pkg::ADDR_W'(1);
                end
            end
            mtq_pkg::ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = mtq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res            = '0;
        o_res.occupancy  = w_occ;
        o_res.error_code = r_err;
        if (w_occ != '0) begin
            o_res.front = r_front;
            // head wins ties
            if (r_tmc != '0 && r_tm.entry.price > r_hm.entry.price) begin
                o_res.best = r_tm.entry;
            end else begin
                o_res.best = r_hm.entry;
            end
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mtq_pkg::CNT_W + 1)'(r_head_cnt) + (mtq_pkg::CNT_W + 1)'(r_tail_cnt)
            <= (mtq_pkg::CNT_W + 1)'(mtq_pkg::DEPTH))
        else $error("queue holds more entries than slots");

    a_head_refilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtq_pkg::ST_IDLE && r_head_cnt == '0) |->
            (r_tail_cnt == '0 && r_hmc == '0))
        else $error("head empty while entries remain");

    a_head_max_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtq_pkg::ST_IDLE && r_head_cnt != '0) |->
            (r_hmc != '0 && r_hmc <= r_head_cnt))
        else $error("head max stack out of step with head stack");

    a_tail_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tmc <= r_tail_cnt)
        else $error("tail max stack deeper than tail stack");

    a_walk_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == mtq_pkg::ST_WALK) |-> $past(r_state) == mtq_pkg::ST_POP)
        else $error("tail move started outside a pop");
`endif

endmodule
`default_nettype wire

@@ rtl/mtq_out_stage.sv @@
// Result register between the sequencer and the output channel.
`default_nettype none
module mtq_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_res_valid,
    input  wire mtq_pkg::t_result i_res,
    output logic                  o_res_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output mtq_pkg::t_result      o_res
);

    logic             r_valid;
    mtq_pkg::t_result r_res;

    assign o_res_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire
